// File: rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion shorthands shared by the RTL. They expand to nothing
// when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed: same-cycle implication");
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed: next-cycle implication");
`else
`define ASSERT_IMPLY(label, clk, rst, ante, cons)
`define ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

// File: rtl/aid_pkg.sv
// ----------------------------------------------------------------------------
// aid_pkg
// Types, codes and constant tables of the Alpha instruction decoder.
// ----------------------------------------------------------------------------
package aid_pkg;

   localparam int NFUNC = 107;

   typedef struct packed {
      logic [31:0] instr_word;
      logic [63:0] instr_addr;
   } aid_req_type;

   typedef struct packed {
      logic [2:0]         inst_class;
      logic [4:0]         listing_kind;
      logic [6:0]         func_index;
      logic [5:0]         opcode;
      logic [10:0]        func_code;
      logic [4:0]         reg_a;
      logic [4:0]         reg_b;
      logic [4:0]         reg_c;
      logic               uses_literal;
      logic [7:0]         literal;
      logic signed [15:0] displacement;
      logic [63:0]        branch_target;
   } aid_rsp_type;

   typedef struct packed {
      logic       hit;
      logic [6:0] idx;
   } aid_lookup_type;

   // Instruction classes.
   localparam logic [2:0] CLS_UNDEF  = 3'd0;
   localparam logic [2:0] CLS_JUMP   = 3'd1;
   localparam logic [2:0] CLS_MEM    = 3'd2;
   localparam logic [2:0] CLS_FPMEM  = 3'd3;
   localparam logic [2:0] CLS_BRANCH = 3'd4;
   localparam logic [2:0] CLS_INTOP  = 3'd5;
   localparam logic [2:0] CLS_FPOP   = 3'd6;

   // Listing kinds.
   localparam logic [4:0] KIND_UNDEF      = 5'd0;
   localparam logic [4:0] KIND_JMP_RB     = 5'd1;
   localparam logic [4:0] KIND_JMP_RA_RB  = 5'd2;
   localparam logic [4:0] KIND_JSR_RB     = 5'd3;
   localparam logic [4:0] KIND_JSR_RA_RB  = 5'd4;
   localparam logic [4:0] KIND_RET        = 5'd5;
   localparam logic [4:0] KIND_RET_RB     = 5'd6;
   localparam logic [4:0] KIND_RET_RA_RB  = 5'd7;
   localparam logic [4:0] KIND_JSR_CO     = 5'd8;
   localparam logic [4:0] KIND_PRIMARY    = 5'd9;
   localparam logic [4:0] KIND_TRAPB      = 5'd10;
   localparam logic [4:0] KIND_BR         = 5'd11;
   localparam logic [4:0] KIND_BSR        = 5'd12;
   localparam logic [4:0] KIND_TABLE      = 5'd13;
   localparam logic [4:0] KIND_FP_MISS    = 5'd14;
   localparam logic [4:0] KIND_NOP        = 5'd15;
   localparam logic [4:0] KIND_CLR        = 5'd16;
   localparam logic [4:0] KIND_MOV        = 5'd17;
   localparam logic [4:0] KIND_FNOP       = 5'd18;
   localparam logic [4:0] KIND_FMOV       = 5'd19;

   // Jump hint codes in bits 15:14.
   localparam logic [1:0] JMP_HINT_JMP = 2'd0;
   localparam logic [1:0] JMP_HINT_JSR = 2'd1;
   localparam logic [1:0] JMP_HINT_RET = 2'd2;

   // Opcodes, function codes and registers with special meaning.
   localparam logic [5:0]  OP_MISC  = 6'h18;
   localparam logic [5:0]  OP_BR    = 6'h30;
   localparam logic [5:0]  OP_BSR   = 6'h34;
   localparam logic [5:0]  OP_INTL  = 6'h11;
   localparam logic [5:0]  OP_FLTL  = 6'h17;
   localparam logic [6:0]  FUN_BIS  = 7'h20;
   localparam logic [10:0] FUN_CPYS = 11'h020;
   localparam logic [4:0]  REG_ZERO = 5'd31;
   localparam logic [4:0]  REG_RA   = 5'd26;

   localparam logic [2:0] CLASS_TABLE [64] = '{
      3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0,
      3'd2, 3'd2, 3'd2, 3'd2, 3'd2, 3'd2, 3'd2, 3'd2,
      3'd5, 3'd5, 3'd5, 3'd5, 3'd0, 3'd0, 3'd6, 3'd6,
      3'd2, 3'd0, 3'd1, 3'd0, 3'd5, 3'd0, 3'd0, 3'd0,
      3'd3, 3'd3, 3'd3, 3'd3, 3'd3, 3'd3, 3'd3, 3'd3,
      3'd2, 3'd2, 3'd2, 3'd2, 3'd2, 3'd2, 3'd2, 3'd2,
      3'd4, 3'd4, 3'd4, 3'd4, 3'd4, 3'd4, 3'd4, 3'd4,
      3'd4, 3'd4, 3'd4, 3'd4, 3'd4, 3'd4, 3'd4, 3'd4
   };

   localparam logic [5:0] FTAB_OP [NFUNC] = '{
      6'h10, 6'h10, 6'h10, 6'h10, 6'h10, 6'h10, 6'h10, 6'h10, 6'h10, 6'h10,
      6'h10, 6'h10, 6'h10, 6'h10, 6'h10, 6'h10, 6'h10, 6'h10, 6'h10, 6'h10,
      6'h10, 6'h10,
      6'h11, 6'h11, 6'h11, 6'h11, 6'h11, 6'h11, 6'h11, 6'h11, 6'h11, 6'h11,
      6'h11, 6'h11, 6'h11, 6'h11,
      6'h12, 6'h12, 6'h12, 6'h12, 6'h12, 6'h12, 6'h12, 6'h12, 6'h12, 6'h12,
      6'h12, 6'h12, 6'h12, 6'h12, 6'h12, 6'h12, 6'h12, 6'h12, 6'h12, 6'h12,
      6'h12, 6'h12, 6'h12, 6'h12, 6'h12, 6'h12,
      6'h13, 6'h13, 6'h13, 6'h13, 6'h13,
      6'h16, 6'h16, 6'h16, 6'h16, 6'h16, 6'h16, 6'h16, 6'h16,
      6'h16, 6'h16, 6'h16, 6'h16, 6'h16, 6'h16, 6'h16, 6'h16,
      6'h16, 6'h16, 6'h16, 6'h16, 6'h16, 6'h17, 6'h16, 6'h16, 6'h17, 6'h16,
      6'h16, 6'h16,
      6'h16, 6'h16, 6'h16, 6'h16, 6'h16, 6'h16, 6'h16, 6'h16,
      6'h17, 6'h17, 6'h1c, 6'h1c
   };

   localparam logic [10:0] FTAB_FUN [NFUNC] = '{
      11'h000, 11'h040, 11'h020, 11'h060, 11'h009, 11'h049, 11'h029, 11'h069,
      11'h02d, 11'h04d, 11'h06d, 11'h01d, 11'h03d, 11'h00f,
      11'h002, 11'h00b, 11'h022, 11'h02b, 11'h012, 11'h01b, 11'h032, 11'h03b,
      11'h000, 11'h020, 11'h040, 11'h008, 11'h028, 11'h048, 11'h024, 11'h044,
      11'h064, 11'h026, 11'h046, 11'h066, 11'h014, 11'h016,
      11'h039, 11'h03c, 11'h034, 11'h030, 11'h031, 11'h006, 11'h016, 11'h026,
      11'h036, 11'h05a, 11'h06a, 11'h07a, 11'h00b, 11'h01b,
      11'h02b, 11'h03b, 11'h057, 11'h067, 11'h077, 11'h002, 11'h012, 11'h022,
      11'h032, 11'h052, 11'h062, 11'h072,
      11'h000, 11'h020, 11'h040, 11'h060, 11'h030,
      11'h080, 11'h0a0, 11'h081, 11'h0a1, 11'h082, 11'h0a2, 11'h083, 11'h0a3,
      11'h580, 11'h5a0, 11'h581, 11'h5a1, 11'h582, 11'h5a2, 11'h583, 11'h5a3,
      11'h0ac, 11'h0bc, 11'h0be, 11'h0af, 11'h02f, 11'h030, 11'h1af, 11'h12f,
      11'h130, 11'h5ac, 11'h5af, 11'h52f,
      11'h0a4, 11'h0a5, 11'h0a6, 11'h0a7, 11'h5a4, 11'h5a5, 11'h5a6, 11'h5a7,
      11'h020, 11'h021, 11'h000, 11'h001
   };

   // Every entry is compared in parallel; scanning from the top down leaves
   // the lowest matching index, which is the first match.
   function automatic aid_lookup_type func_lookup(input logic [5:0] op,
                                                  input logic [10:0] fun);
      aid_lookup_type res;
      res = '0;
      for (int i = NFUNC - 1; i >= 0; i--) begin
         if (FTAB_OP[i] == op && FTAB_FUN[i] == fun) begin
            res.hit = 1'b1;
            res.idx = 7'(i);
         end
      end
      return res;
   endfunction

endpackage

// File: rtl/aid_decode.sv
// ----------------------------------------------------------------------------
// aid_decode
// Decode logic for one instruction word: class, listing kind, table index,
// field extraction and branch target.
// ----------------------------------------------------------------------------
module aid_decode (
   input  aid_pkg::aid_req_type req,
   output aid_pkg::aid_rsp_type rsp
);
   import aid_pkg::*;

   logic [31:0]         c;
   logic [5:0]          op;
   logic [6:0]          fun7;
   logic [10:0]         fun11;
   logic [4:0]          ra;
   logic [4:0]          rb;
   logic [4:0]          rc;
   logic                litbit;
   logic [2:0]          cls;
   logic [4:0]          kind;
   logic [6:0]          idx;
   aid_lookup_type      int_hit;
   aid_lookup_type      fp_hit;
   logic signed [21:0]  off_inc;

   assign c      = req.instr_word;
   assign op     = c[31:26];
   assign fun7   = c[11:5];
   assign fun11  = c[15:5];
   assign ra     = c[25:21];
   assign rb     = c[20:16];
   assign rc     = c[4:0];
   assign litbit = c[12];
   assign cls    = CLASS_TABLE[op];

   assign int_hit = func_lookup(op, {4'd0, fun7});
   assign fp_hit  = func_lookup(op, fun11);

   // The extra 4 bytes are folded into the offset so one 64-bit add remains.
   assign off_inc = $signed({c[20], c[20:0]}) + 22'sd1;

   always_comb begin
      kind = KIND_UNDEF;
      idx  = '0;
      unique case (cls)
         CLS_JUMP: begin
            unique case (c[15:14])
               JMP_HINT_JMP: kind = (ra == REG_ZERO) ? KIND_JMP_RB : KIND_JMP_RA_RB;
               JMP_HINT_JSR: kind = (ra == REG_RA) ? KIND_JSR_RB : KIND_JSR_RA_RB;
               JMP_HINT_RET: begin
                  if (ra == REG_ZERO && rb == REG_RA) kind = KIND_RET;
                  else if (ra == REG_ZERO) kind = KIND_RET_RB;
                  else kind = KIND_RET_RA_RB;
               end
               default: kind = KIND_JSR_CO;
            endcase
         end
         CLS_MEM: begin
            kind = (op == OP_MISC && ra == 5'd0 && c[15:0] == 16'd0) ? KIND_TRAPB
                                                                     : KIND_PRIMARY;
         end
         CLS_FPMEM: kind = KIND_PRIMARY;
         CLS_BRANCH: begin
            if (op == OP_BR && ra == REG_ZERO) kind = KIND_BR;
            else if (op == OP_BSR && ra == REG_RA) kind = KIND_BSR;
            else kind = KIND_PRIMARY;
         end
         CLS_INTOP: begin
            if (op == OP_INTL && fun7 == FUN_BIS && ra == rb && !litbit) begin
               if (ra == REG_ZERO && rc == REG_ZERO) kind = KIND_NOP;
               else if (ra == REG_ZERO) kind = KIND_CLR;
               else kind = KIND_MOV;
            end else if (int_hit.hit) begin
               kind = KIND_TABLE;
               idx  = int_hit.idx;
            end
         end
         CLS_FPOP: begin
            if (op == OP_FLTL && fun11 == FUN_CPYS && ra == rb) begin
               kind = (ra == REG_ZERO && rc == REG_ZERO) ? KIND_FNOP : KIND_FMOV;
            end else if (fp_hit.hit) begin
               kind = KIND_TABLE;
               idx  = fp_hit.idx;
            end else begin
               kind = KIND_FP_MISS;
            end
         end
         default: kind = KIND_UNDEF;
      endcase
   end

   always_comb begin
      rsp.inst_class    = cls;
      rsp.listing_kind  = kind;
      rsp.func_index    = idx;
      rsp.opcode        = op;
      rsp.func_code     = (cls == CLS_FPOP) ? fun11 : {4'd0, fun7};
      rsp.reg_a         = ra;
      rsp.reg_b         = rb;
      rsp.reg_c         = rc;
      rsp.uses_literal  = litbit;
      rsp.literal       = c[20:13];
      rsp.displacement  = $signed(c[15:0]);
      rsp.branch_target = req.instr_addr + {{40{off_inc[21]}}, off_inc, 2'b00};
   end

endmodule

// File: rtl/alpha_instruction_decoder.sv
// ----------------------------------------------------------------------------
// alpha_instruction_decoder: Alpha instruction word decoder, one word per cycle.
// Pipeline: an input register holds the word, and a result register holds its decode.
// Throughput: one transfer per cycle; the stages stall only on rsp_ready low.
// Reset: synchronous, active high; clears both stage valid flags.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module alpha_instruction_decoder (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  aid_pkg::aid_req_type req_data,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output aid_pkg::aid_rsp_type rsp_data
);
   import aid_pkg::*;

   logic        s1_valid_ff;
   logic        s1_valid_in;
   aid_req_type s1_data_ff;
   logic        rsp_valid_ff;
   logic        rsp_valid_in;
   aid_rsp_type rsp_data_ff;
   aid_rsp_type dec_rsp;
   logic        rsp_free;
   logic        s1_free;
   logic        s1_move;

   assign rsp_free  = !rsp_valid_ff || rsp_ready;
   assign s1_move   = s1_valid_ff && rsp_free;
   assign s1_free   = !s1_valid_ff || rsp_free;
   assign req_ready = s1_free;

   aid_decode u_decode (
      .req (s1_data_ff),
      .rsp (dec_rsp)
   );

   always_comb begin
      s1_valid_in  = s1_free ? req_valid : s1_valid_ff;
      rsp_valid_in = rsp_free ? s1_valid_ff : rsp_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && s1_free) begin
         s1_data_ff <= req_data;
      end
      if (s1_move) begin
         rsp_data_ff <= dec_rsp;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // A decoded word moves into the result register whenever that register is free.
   `ASSERT_NEXT(a_stage_advance, clock, reset, s1_move, rsp_valid_ff)
   // A table index is only given for operate classes.
   `ASSERT_IMPLY(a_table_class, clock, reset, rsp_valid_ff && rsp_data_ff.listing_kind == KIND_TABLE, rsp_data_ff.inst_class == CLS_INTOP || rsp_data_ff.inst_class == CLS_FPOP)
   // A nonzero index implies a table hit.
   `ASSERT_IMPLY(a_index_kind, clock, reset, rsp_valid_ff && rsp_data_ff.func_index != 7'd0, rsp_data_ff.listing_kind == KIND_TABLE)
   // Undefined opcodes never get a listing form.
   `ASSERT_IMPLY(a_undef_kind, clock, reset, rsp_valid_ff && rsp_data_ff.inst_class == CLS_UNDEF, rsp_data_ff.listing_kind == KIND_UNDEF)

endmodule

// File: verif/alpha_instruction_decoder_tb.sv
// ----------------------------------------------------------------------------
// alpha_instruction_decoder_tb
// Self-checking bench for the Alpha instruction decoder. A queue of directed
// and random instruction words feeds a valid/ready driver. A monitor compares
// every result transfer, field by field, with a decode worked out in the bench
// from its own class function and copy of the function table. Both sides
// idle at random in the first two of three phases, and the result side holds
// off once for a long stretch so that the pipeline fills and stalls its input.
// ----------------------------------------------------------------------------
module alpha_instruction_decoder_tb;
   import aid_pkg::*;

   localparam int WATCHDOG_LIMIT = 2000;
   localparam int SETTLE_CYCLES  = 8;
   localparam int HOLD_CYCLES    = 60;
   localparam int PHASE_WORDS    = 400;
   localparam int FUNC_ENTRIES   = 107;
   localparam int KIND_COUNT     = 20;

   localparam logic [5:0] OP_INTA    = 6'h10;
   localparam logic [5:0] OP_FLTI    = 6'h16;
   localparam logic [5:0] OP_JUMP    = 6'h1a;
   localparam logic [5:0] OP_INTMISC = 6'h1c;
   localparam logic [5:0] OP_LDF     = 6'h20;
   localparam logic [1:0] JMP_HINT_JSR_CO = 2'd3;

   // Function table: opcode and function code of each entry, first match wins.
   localparam logic [5:0] FUNC_OP [FUNC_ENTRIES] = '{
      6'h10, 6'h10, 6'h10, 6'h10, 6'h10, 6'h10, 6'h10, 6'h10, 6'h10, 6'h10,
      6'h10, 6'h10, 6'h10, 6'h10, 6'h10, 6'h10, 6'h10, 6'h10, 6'h10, 6'h10,
      6'h10, 6'h10,
      6'h11, 6'h11, 6'h11, 6'h11, 6'h11, 6'h11, 6'h11, 6'h11, 6'h11, 6'h11,
      6'h11, 6'h11, 6'h11, 6'h11,
      6'h12, 6'h12, 6'h12, 6'h12, 6'h12, 6'h12, 6'h12, 6'h12, 6'h12, 6'h12,
      6'h12, 6'h12, 6'h12, 6'h12, 6'h12, 6'h12, 6'h12, 6'h12, 6'h12, 6'h12,
      6'h12, 6'h12, 6'h12, 6'h12, 6'h12, 6'h12,
      6'h13, 6'h13, 6'h13, 6'h13, 6'h13,
      6'h16, 6'h16, 6'h16, 6'h16, 6'h16, 6'h16, 6'h16, 6'h16,
      6'h16, 6'h16, 6'h16, 6'h16, 6'h16, 6'h16, 6'h16, 6'h16,
      6'h16, 6'h16, 6'h16, 6'h16, 6'h16, 6'h17, 6'h16, 6'h16, 6'h17, 6'h16,
      6'h16, 6'h16,
      6'h16, 6'h16, 6'h16, 6'h16, 6'h16, 6'h16, 6'h16, 6'h16,
      6'h17, 6'h17, 6'h1c, 6'h1c
   };

   localparam logic [10:0] FUNC_FUN [FUNC_ENTRIES] = '{
      11'h000, 11'h040, 11'h020, 11'h060, 11'h009, 11'h049, 11'h029, 11'h069,
      11'h02d, 11'h04d, 11'h06d, 11'h01d, 11'h03d, 11'h00f,
      11'h002, 11'h00b, 11'h022, 11'h02b, 11'h012, 11'h01b, 11'h032, 11'h03b,
      11'h000, 11'h020, 11'h040, 11'h008, 11'h028, 11'h048, 11'h024, 11'h044,
      11'h064, 11'h026, 11'h046, 11'h066, 11'h014, 11'h016,
      11'h039, 11'h03c, 11'h034, 11'h030, 11'h031, 11'h006, 11'h016, 11'h026,
      11'h036, 11'h05a, 11'h06a, 11'h07a, 11'h00b, 11'h01b,
      11'h02b, 11'h03b, 11'h057, 11'h067, 11'h077, 11'h002, 11'h012, 11'h022,
      11'h032, 11'h052, 11'h062, 11'h072,
      11'h000, 11'h020, 11'h040, 11'h060, 11'h030,
      11'h080, 11'h0a0, 11'h081, 11'h0a1, 11'h082, 11'h0a2, 11'h083, 11'h0a3,
      11'h580, 11'h5a0, 11'h581, 11'h5a1, 11'h582, 11'h5a2, 11'h583, 11'h5a3,
      11'h0ac, 11'h0bc, 11'h0be, 11'h0af, 11'h02f, 11'h030, 11'h1af, 11'h12f,
      11'h130, 11'h5ac, 11'h5af, 11'h52f,
      11'h0a4, 11'h0a5, 11'h0a6, 11'h0a7, 11'h5a4, 11'h5a5, 11'h5a6, 11'h5a7,
      11'h020, 11'h021, 11'h000, 11'h001
   };

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   aid_req_type req_data = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   aid_rsp_type rsp_data;

   aid_req_type words_to_issue [$];
   aid_rsp_type expected_decodes [$];

   int send_gap_pct = 0;
   int stall_pct = 0;
   int hold_left = 0;
   bit hold_start = 1'b0;
   int idle_cycles = 0;
   int mismatches = 0;
   int words_decoded = 0;
   int kind_hits [KIND_COUNT];

   alpha_instruction_decoder uut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic logic [2:0] class_of(logic [5:0] op);
      casez (op)
         6'b000???: return CLS_UNDEF;
         6'b001???: return CLS_MEM;
         6'b0100??: return CLS_INTOP;
         6'h16, 6'h17: return CLS_FPOP;
         6'h18: return CLS_MEM;
         6'h1a: return CLS_JUMP;
         6'h1c: return CLS_INTOP;
         6'h14, 6'h15, 6'h19, 6'h1b, 6'h1d, 6'h1e, 6'h1f: return CLS_UNDEF;
         6'b100???: return CLS_FPMEM;
         6'b101???: return CLS_MEM;
         default: return CLS_BRANCH;
      endcase
   endfunction

   function automatic int find_func(logic [5:0] op, logic [10:0] fun);
      for (int i = 0; i < FUNC_ENTRIES; i++) begin
         if (FUNC_OP[i] == op && FUNC_FUN[i] == fun) return i;
      end
      return -1;
   endfunction

   function automatic aid_rsp_type decode_word(aid_req_type item);
      aid_rsp_type d;
      logic [31:0] w;
      logic [6:0]  fun7;
      logic [10:0] fun11;
      logic [63:0] offset;
      int          hit;
      w = item.instr_word;
      fun7 = w[11:5];
      fun11 = w[15:5];
      offset = {{43{w[20]}}, w[20:0]};
      d = '0;
      d.opcode = w[31:26];
      d.reg_a = w[25:21];
      d.reg_b = w[20:16];
      d.reg_c = w[4:0];
      d.uses_literal = w[12];
      d.literal = w[20:13];
      d.displacement = w[15:0];
      d.branch_target = item.instr_addr + 64'd4 + (offset << 2);
      d.func_code = {4'b0000, fun7};
      d.inst_class = class_of(d.opcode);
      d.listing_kind = KIND_UNDEF;
      case (d.inst_class)
         CLS_JUMP: begin
            case (w[15:14])
               JMP_HINT_JMP:
                  d.listing_kind = (d.reg_a == REG_ZERO) ? KIND_JMP_RB : KIND_JMP_RA_RB;
               JMP_HINT_JSR:
                  d.listing_kind = (d.reg_a == REG_RA) ? KIND_JSR_RB : KIND_JSR_RA_RB;
               JMP_HINT_RET: begin
                  if (d.reg_a == REG_ZERO && d.reg_b == REG_RA) d.listing_kind = KIND_RET;
                  else if (d.reg_a == REG_ZERO) d.listing_kind = KIND_RET_RB;
                  else d.listing_kind = KIND_RET_RA_RB;
               end
               default: d.listing_kind = KIND_JSR_CO;
            endcase
         end
         CLS_MEM: begin
            if (d.opcode == OP_MISC && d.reg_a == 5'd0 && w[15:0] == 16'h0000)
               d.listing_kind = KIND_TRAPB;
            else
               d.listing_kind = KIND_PRIMARY;
         end
         CLS_FPMEM: d.listing_kind = KIND_PRIMARY;
         CLS_BRANCH: begin
            if (d.opcode == OP_BR && d.reg_a == REG_ZERO) d.listing_kind = KIND_BR;
            else if (d.opcode == OP_BSR && d.reg_a == REG_RA) d.listing_kind = KIND_BSR;
            else d.listing_kind = KIND_PRIMARY;
         end
         CLS_INTOP: begin
            // The move aliases only apply to the register form (bit 12 clear).
            if (d.opcode == OP_INTL && fun7 == FUN_BIS && d.reg_a == d.reg_b && !w[12]) begin
               if (d.reg_a == REG_ZERO && d.reg_c == REG_ZERO) d.listing_kind = KIND_NOP;
               else if (d.reg_a == REG_ZERO) d.listing_kind = KIND_CLR;
               else d.listing_kind = KIND_MOV;
            end else begin
               hit = find_func(d.opcode, {4'b0000, fun7});
               if (hit >= 0) begin
                  d.listing_kind = KIND_TABLE;
                  d.func_index = 7'(hit);
               end
            end
         end
         CLS_FPOP: begin
            d.func_code = fun11;
            if (d.opcode == OP_FLTL && fun11 == FUN_CPYS && d.reg_a == d.reg_b) begin
               d.listing_kind = (d.reg_a == REG_ZERO && d.reg_c == REG_ZERO) ?
                                KIND_FNOP : KIND_FMOV;
            end else begin
               hit = find_func(d.opcode, fun11);
               if (hit >= 0) begin
                  d.listing_kind = KIND_TABLE;
                  d.func_index = 7'(hit);
               end else begin
                  d.listing_kind = KIND_FP_MISS;
               end
            end
         end
         default: ;
      endcase
      return d;
   endfunction

   function automatic logic [4:0] pick_reg();
      case ($urandom_range(4))
         0: return REG_ZERO;
         1: return REG_RA;
         2: return 5'd0;
         default: return 5'($urandom);
      endcase
   endfunction

   function automatic logic [63:0] pick_addr();
      case ($urandom_range(9))
         0: return 64'($urandom_range(255));
         1: return ~64'($urandom_range(255));
         default: return {$urandom, $urandom};
      endcase
   endfunction

   // Mostly well-formed operate, jump, branch and misc words, with the alias fields steered
   // toward the registers that matter; the rest is raw noise.
   function automatic aid_req_type random_item();
      aid_req_type it;
      int          pick;
      int          entry;
      logic [4:0]  ra;
      logic [4:0]  rb;
      logic [15:0] low;
      pick = $urandom_range(99);
      ra = pick_reg();
      rb = pick_reg();
      low = 16'($urandom);
      if ($urandom_range(3) == 0) low[4:0] = REG_ZERO;
      if (pick < 15) begin
         it.instr_word = $urandom;
      end else if (pick < 50) begin
         entry = $urandom_range(FUNC_ENTRIES - 1);
         if (class_of(FUNC_OP[entry]) == CLS_FPOP) low[15:5] = FUNC_FUN[entry];
         else low[11:5] = FUNC_FUN[entry][6:0];
         it.instr_word = {FUNC_OP[entry], ra, rb, low};
      end else if (pick < 62) begin
         if ($urandom_range(1) == 1) begin
            low[11:5] = FUN_BIS;
            low[12] = ($urandom_range(3) == 0);
            it.instr_word = {OP_INTL, ra, ($urandom_range(4) == 0) ? rb : ra, low};
         end else begin
            low[15:5] = FUN_CPYS;
            it.instr_word = {OP_FLTL, ra, ($urandom_range(4) == 0) ? rb : ra, low};
         end
      end else if (pick < 74) begin
         it.instr_word = {OP_JUMP, ra, rb, low};
      end else if (pick < 88) begin
         case ($urandom_range(2))
            0: it.instr_word = {OP_BR, ra, rb, low};
            1: it.instr_word = {OP_BSR, ra, rb, low};
            default: it.instr_word = {2'b11, 4'($urandom), ra, rb, low};
         endcase
      end else begin
         if ($urandom_range(1) == 1) low = '0;
         it.instr_word = {OP_MISC, ($urandom_range(1) == 1) ? 5'd0 : ra, rb, low};
      end
      it.instr_addr = pick_addr();
      return it;
   endfunction

   task automatic queue_word(logic [31:0] word, logic [63:0] addr);
      aid_req_type it;
      it.instr_word = word;
      it.instr_addr = addr;
      words_to_issue.push_back(it);
   endtask

   task automatic wait_for_drain();
      while (words_to_issue.size() != 0 || req_valid || expected_decodes.size() != 0)
         @(negedge clock);
   endtask

   task automatic compare_decode(aid_rsp_type exp, aid_rsp_type got);
      if (got.inst_class !== exp.inst_class) begin
         $error("inst_class: expected %0d, got %0d", exp.inst_class, got.inst_class);
         mismatches++;
      end
      if (got.listing_kind !== exp.listing_kind) begin
         $error("listing_kind: expected %0d, got %0d", exp.listing_kind, got.listing_kind);
         mismatches++;
      end
      if (got.func_index !== exp.func_index) begin
         $error("func_index: expected %0d, got %0d", exp.func_index, got.func_index);
         mismatches++;
      end
      if (got.opcode !== exp.opcode) begin
         $error("opcode: expected %0h, got %0h", exp.opcode, got.opcode);
         mismatches++;
      end
      if (got.func_code !== exp.func_code) begin
         $error("func_code: expected %0h, got %0h", exp.func_code, got.func_code);
         mismatches++;
      end
      if (got.reg_a !== exp.reg_a) begin
         $error("reg_a: expected %0d, got %0d", exp.reg_a, got.reg_a);
         mismatches++;
      end
      if (got.reg_b !== exp.reg_b) begin
         $error("reg_b: expected %0d, got %0d", exp.reg_b, got.reg_b);
         mismatches++;
      end
      if (got.reg_c !== exp.reg_c) begin
         $error("reg_c: expected %0d, got %0d", exp.reg_c, got.reg_c);
         mismatches++;
      end
      if (got.uses_literal !== exp.uses_literal) begin
         $error("uses_literal: expected %0b, got %0b", exp.uses_literal, got.uses_literal);
         mismatches++;
      end
      if (got.literal !== exp.literal) begin
         $error("literal: expected %0d, got %0d", exp.literal, got.literal);
         mismatches++;
      end
      if (got.displacement !== exp.displacement) begin
         $error("displacement: expected %0d, got %0d", exp.displacement, got.displacement);
         mismatches++;
      end
      if (got.branch_target !== exp.branch_target) begin
         $error("branch_target: expected %h, got %h", exp.branch_target, got.branch_target);
         mismatches++;
      end
   endtask

   // Driver: a new word goes out only when the slot is free or being taken.
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready) expected_decodes.push_back(decode_word(req_data));
         if (!req_valid || req_ready) begin
            if (words_to_issue.size() != 0 && $urandom_range(99) >= send_gap_pct) begin
               req_valid <= 1'b1;
               req_data <= words_to_issue.pop_front();
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (hold_start) hold_left <= HOLD_CYCLES;
      else if (hold_left != 0) hold_left <= hold_left - 1;
   end

   // Monitor: check each result transfer against the oldest pending decode.
   always @(posedge clock) begin
      aid_rsp_type exp;
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (expected_decodes.size() == 0) begin
               $error("result transfer with no decode pending");
               mismatches++;
            end else begin
               exp = expected_decodes.pop_front();
               compare_decode(exp, rsp_data);
               if (exp.listing_kind < KIND_COUNT) kind_hits[exp.listing_kind]++;
               words_decoded++;
            end
         end
         rsp_ready <= (hold_left == 0) && ($urandom_range(99) >= stall_pct);
      end
   end

   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("TB_ERROR");
         $finish;
      end
   end

   initial begin
      int kinds_seen;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      queue_word(32'h0000_0000, 64'h0);
      queue_word(32'hffff_ffff, 64'hffff_ffff_ffff_ffff);
      queue_word({OP_JUMP, REG_ZERO, 5'd4, JMP_HINT_JMP, 14'h0000}, pick_addr());
      queue_word({OP_JUMP, 5'd3, 5'd4, JMP_HINT_JMP, 14'h1234}, pick_addr());
      queue_word({OP_JUMP, REG_RA, 5'd4, JMP_HINT_JSR, 14'h3fff}, pick_addr());
      queue_word({OP_JUMP, 5'd1, 5'd5, JMP_HINT_JSR, 14'h0001}, pick_addr());
      queue_word({OP_JUMP, REG_ZERO, REG_RA, JMP_HINT_RET, 14'h0001}, pick_addr());
      queue_word({OP_JUMP, REG_ZERO, 5'd7, JMP_HINT_RET, 14'h0000}, pick_addr());
      queue_word({OP_JUMP, 5'd2, REG_RA, JMP_HINT_RET, 14'h2000}, pick_addr());
      queue_word({OP_JUMP, 5'd9, 5'd9, JMP_HINT_JSR_CO, 14'h0abc}, pick_addr());
      // Trap barrier needs both ra and the displacement at zero.
      queue_word({OP_MISC, 5'd0, 5'd0, 16'h0000}, pick_addr());
      queue_word({OP_MISC, 5'd0, 5'd0, 16'h8000}, pick_addr());
      // Largest forward and backward branch offsets, the latter wrapping below zero.
      queue_word({OP_BR, REG_ZERO, 21'h0fffff}, 64'h0);
      queue_word({OP_BSR, REG_RA, 21'h100000}, 64'h0);
      queue_word({OP_INTL, REG_ZERO, REG_ZERO, 3'b000, 1'b0, FUN_BIS, REG_ZERO}, pick_addr());
      queue_word({OP_INTL, REG_ZERO, REG_ZERO, 3'b000, 1'b0, FUN_BIS, 5'd1}, pick_addr());
      queue_word({OP_INTL, 5'd7, 5'd7, 3'b101, 1'b0, FUN_BIS, 5'd8}, pick_addr());
      queue_word({OP_INTL, REG_ZERO, REG_ZERO, 3'b111, 1'b1, FUN_BIS, 5'd2}, pick_addr());
      queue_word({OP_INTA, 5'd1, 5'd2, 4'h0, 7'h7f, 5'd3}, pick_addr());
      queue_word({OP_INTMISC, 5'd1, 5'd2, 4'hf, 7'h01, 5'd3}, pick_addr());
      queue_word({OP_FLTL, REG_ZERO, REG_ZERO, FUN_CPYS, REG_ZERO}, pick_addr());
      queue_word({OP_FLTL, 5'd4, 5'd4, FUN_CPYS, 5'd5}, pick_addr());
      queue_word({OP_FLTI, 5'd1, 5'd2, 11'h7ff, 5'd3}, pick_addr());
      queue_word({OP_FLTI, 5'd1, 5'd2, 11'h5a7, 5'd3}, pick_addr());
      queue_word({OP_LDF, 5'd6, 5'd7, 16'h7fff}, pick_addr());
      wait_for_drain();

      for (int phase = 0; phase < 3; phase++) begin
         case (phase)
            0: begin send_gap_pct = 18; stall_pct = 50; end
            1: begin send_gap_pct = 50; stall_pct = 18; end
            default: begin send_gap_pct = 0; stall_pct = 0; end
         endcase
         repeat (PHASE_WORDS) words_to_issue.push_back(random_item());
         if (phase == 2) begin
            // Result side goes quiet while words keep coming, so the pipe backs up.
            hold_start = 1'b1;
            @(negedge clock);
            hold_start = 1'b0;
         end
         wait_for_drain();
      end

      repeat (SETTLE_CYCLES) @(posedge clock);
      kinds_seen = 0;
      for (int k = 0; k < KIND_COUNT; k++) if (kind_hits[k] != 0) kinds_seen++;
      $display("Checked %0d decoded words under three idle mixes and one long result stall.",
               words_decoded);
      $display("Listing kinds exercised: %0d of %0d.", kinds_seen, KIND_COUNT);
      if (mismatches == 0) $display("TB_OK");
      else $display("TB_ERROR");
      $finish;
   end

endmodule
